### src/dfgs_pkg.sv
// shared types and codes for the receiver frame decoder
package dfgs_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SW_UP     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_MID    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_DOWN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_UP    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_DOWN  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEFT  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_RIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CTR   = 4'd7;

  typedef enum logic [1:0] {
    POS_UP   = 2'd0,
    POS_MID  = 2'd1,
    POS_DOWN = 2'd2,
    POS_NONE = 2'd3
  } sw_pos_t;

  localparam logic [1:0] MODE_REMOTE = 2'd0;
  localparam logic [1:0] MODE_KEY    = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  typedef enum logic [2:0] {
    KEY_NONE  = 3'd0,
    KEY_UP    = 3'd1,
    KEY_DOWN  = 3'd2,
    KEY_LEFT  = 3'd3,
    KEY_RIGHT = 3'd4
  } key_cls_t;

  typedef struct packed {
    logic signed [10:0] d0;
    logic signed [10:0] d1;
    logic signed [10:0] d2;
    logic signed [10:0] d3;
    sw_pos_t            p1;
    sw_pos_t            p2;
    key_cls_t           key;
    logic               center_hit;
    logic               press_one;
    logic               prep;
    logic               centered;
  } item_t;

endpackage

### src/dfgs_front.sv
// frame unpacking, switch and key classification, configuration registers
module dfgs_front import dfgs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [63:0]           frame_low,
  input  logic [63:0]           frame_high,
  input  logic                  preparing,
  output item_t                 item
);

  logic [1:0]  sw_up, sw_mid, sw_down;
  logic [15:0] key_up, key_down, key_left, key_right, key_ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_up     <= 2'd1;
      sw_mid    <= 2'd3;
      sw_down   <= 2'd2;
      key_up    <= 16'd1;
      key_down  <= 16'd2;
      key_left  <= 16'd4;
      key_right <= 16'd8;
      key_ctr   <= 16'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SW_UP:     sw_up     <= cfg_data[1:0];
        CFG_SW_MID:    sw_mid    <= cfg_data[1:0];
        CFG_SW_DOWN:   sw_down   <= cfg_data[1:0];
        CFG_KEY_UP:    key_up    <= cfg_data;
        CFG_KEY_DOWN:  key_down  <= cfg_data;
        CFG_KEY_LEFT:  key_left  <= cfg_data;
        CFG_KEY_RIGHT: key_right <= cfg_data;
        CFG_KEY_CTR:   key_ctr   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic sw_pos_t classify(input logic [1:0] s, input logic [1:0] up,
                                       input logic [1:0] mid, input logic [1:0] dn);
    sw_pos_t p;
    priority if (s == up) p = POS_UP;
    else if (s == mid)    p = POS_MID;
    else if (s == dn)     p = POS_DOWN;
    else                  p = POS_NONE;
    return p;
  endfunction

  logic [10:0] c0, c1, c2, c3;
  logic [15:0] key;

  assign c0  = frame_low[10:0];
  assign c1  = frame_low[21:11];
  assign c2  = frame_low[32:22];
  assign c3  = frame_low[43:33];
  assign key = frame_high[63:48];

  always_comb begin
    // stick minus 1024 is the code with its top bit flipped
    item.d0 = signed'({~c0[10], c0[9:0]});
    item.d1 = signed'({~c1[10], c1[9:0]});
    item.d2 = signed'({~c2[10], c2[9:0]});
    item.d3 = signed'({~c3[10], c3[9:0]});
    item.p2 = classify(frame_low[45:44], sw_up, sw_mid, sw_down);
    item.p1 = classify(frame_low[47:46], sw_up, sw_mid, sw_down);
    priority if (key == key_up) item.key = KEY_UP;
    else if (key == key_down)   item.key = KEY_DOWN;
    else if (key == key_left)   item.key = KEY_LEFT;
    else if (key == key_right)  item.key = KEY_RIGHT;
    else                        item.key = KEY_NONE;
    item.center_hit = (key == key_ctr);
    item.press_one  = (frame_high[39:32] == 8'd1);
    item.prep       = preparing;
    item.centered   = (c0 == 11'd1024) && (c1 == 11'd1024) &&
                      (c2 == 11'd1024) && (c3 == 11'd1024);
  end

endmodule

### src/dfgs_queue.sv
// small fifo of classified frames between front and back
module dfgs_queue import dfgs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/dfgs_back.sv
// mode, setpoint and command state update with the result register
module dfgs_back import dfgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         input_mode,
  output logic signed [15:0] rate_x,
  output logic signed [15:0] rate_y,
  output logic signed [14:0] horizontal_setpoint,
  output logic signed [15:0] vertical_setpoint,
  output logic [9:0]         fire_rate,
  output logic               shooter_on,
  output logic [6:0]         shooter_speed,
  output logic               laser_on,
  output logic               gear_down,
  output logic               sticks_centered
);

  function automatic logic signed [17:0] clamp(input logic signed [17:0] v,
                                               input logic signed [17:0] lo,
                                               input logic signed [17:0] hi);
    logic signed [17:0] r;
    priority if (v < lo) r = lo;
    else if (v > hi)     r = hi;
    else                 r = v;
    return r;
  endfunction

  logic               recenter;
  logic [1:0]         mode_next;
  logic               recenter_next;
  logic signed [17:0] h_base, v_base, h1, v1, h2;
  logic signed [17:0] h_next, v_next;
  logic signed [15:0] rate_x_next, rate_y_next;
  logic [9:0]         fire_next;
  logic               shoot_next, laser_next, gear_next;
  logic [6:0]         speed_next;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  assign h_base = 18'(horizontal_setpoint);
  assign v_base = 18'(vertical_setpoint);

  always_comb begin
    mode_next     = (q_item.p2 != POS_NONE) ? q_item.p2 : input_mode;
    recenter_next = recenter;
    h_next        = h_base;
    v_next        = v_base;
    h1            = h_base;
    v1            = v_base;
    h2            = h_base;
    rate_x_next   = rate_x;
    rate_y_next   = rate_y;
    fire_next     = fire_rate;
    shoot_next    = shooter_on;
    speed_next    = shooter_speed;
    laser_next    = laser_on;
    gear_next     = gear_down;
    if (mode_next == MODE_REMOTE) begin
      if (!q_item.prep) begin
        rate_x_next = 16'(q_item.d0) * 16'sd22;
        rate_y_next = 16'(q_item.d1) * 16'sd22;
        h1          = h_base - 18'(q_item.d2);
        v1          = v_base - 18'(q_item.d3) * 18'sd10;
        h_next      = clamp(h1, -18'sd13000, 18'sd5000);
        v_next      = clamp(v1, -18'sd28000, 18'sd18000);
      end
      unique case (q_item.p1)
        POS_UP: begin
          fire_next = 10'd0; shoot_next = 1'b0; speed_next = 7'd0;
        end
        POS_MID: begin
          fire_next = 10'd0; shoot_next = 1'b1; speed_next = 7'd120;
        end
        POS_DOWN: begin
          fire_next = 10'd1000; shoot_next = 1'b1; speed_next = 7'd120;
        end
        default: ;
      endcase
      laser_next = 1'b1;
      gear_next  = 1'b1;
    end else if (mode_next == MODE_KEY) begin
      unique case (q_item.key)
        KEY_UP:    v1 = v_base - 18'sd590;
        KEY_DOWN:  v1 = v_base + 18'sd590;
        KEY_LEFT:  h1 = h_base + 18'sd150;
        KEY_RIGHT: h1 = h_base - 18'sd150;
        default: ;
      endcase
      recenter_next = recenter || q_item.center_hit;
      h2 = h1;
      if (recenter_next) begin
        priority if (h1 > 18'sd200) h2 = h1 - 18'sd80;
        else if (h1 < -18'sd200)    h2 = h1 + 18'sd80;
        else                        recenter_next = 1'b0;
      end
      fire_next  = q_item.press_one ? 10'd400 : 10'd0;
      shoot_next = 1'b1;
      speed_next = 7'd125;
      h_next     = clamp(h2, -18'sd13000, 18'sd5000);
      v_next     = clamp(v1, -18'sd32000, 18'sd22000);
      laser_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid           <= 1'b0;
      input_mode          <= MODE_REMOTE;
      recenter            <= 1'b0;
      horizontal_setpoint <= '0;
      vertical_setpoint   <= '0;
      rate_x              <= '0;
      rate_y              <= '0;
      fire_rate           <= '0;
      shooter_on          <= 1'b0;
      shooter_speed       <= '0;
      laser_on            <= 1'b0;
      gear_down           <= 1'b0;
    end else begin
      if (q_pop) begin
        out_valid           <= 1'b1;
        input_mode          <= mode_next;
        recenter            <= recenter_next;
        horizontal_setpoint <= h_next[14:0];
        vertical_setpoint   <= v_next[15:0];
        rate_x              <= rate_x_next;
        rate_y              <= rate_y_next;
        fire_rate           <= fire_next;
        shooter_on          <= shoot_next;
        shooter_speed       <= speed_next;
        laser_on            <= laser_next;
        gear_down           <= gear_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sticks_centered <= q_item.centered;
    end
  end

endmodule

### src/dbus_frame_gimbal_setpoint.sv
// top level of the receiver frame decoder with gimbal setpoint keeping
// Takes one 16-byte receiver frame per transaction and returns one result per
// frame: the held mode, stick rates, horizontal and vertical setpoints in
// hundredths, shooter, laser and gear commands, and a sticks-centered flag.
// A new frame is taken every cycle while the fifo has room; an accepted frame is
// written into the fifo, and the result register is loaded when the back pops it.
// The front classifies each frame against the switch and key codes, a
// QUEUE_DEPTH-entry fifo (2 or more) holds classified frames, and the back
// applies one frame per cycle, while the result register is not stalled, to the
// held state, which is set by the combinational state update feeding the result
// register. Configuration writes (index 0 to 7, others ignored) take effect at
// once and belong in idle periods.
module dbus_frame_gimbal_setpoint import dfgs_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [63:0]           frame_low,
  input  logic [63:0]           frame_high,
  input  logic                  preparing,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            input_mode,
  output logic signed [15:0]    rate_x,
  output logic signed [15:0]    rate_y,
  output logic signed [14:0]    horizontal_setpoint,
  output logic signed [15:0]    vertical_setpoint,
  output logic [9:0]            fire_rate,
  output logic                  shooter_on,
  output logic [6:0]            shooter_speed,
  output logic                  laser_on,
  output logic                  gear_down,
  output logic                  sticks_centered
);

  item_t front_item, q_item;
  logic  q_full, q_valid, q_pop;

  assign in_stall = q_full;

  dfgs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .frame_low  (frame_low),
    .frame_high (frame_high),
    .preparing  (preparing),
    .item       (front_item)
  );

  dfgs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .full      (q_full),
    .not_empty (q_valid)
  );

  dfgs_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .input_mode          (input_mode),
    .rate_x              (rate_x),
    .rate_y              (rate_y),
    .horizontal_setpoint (horizontal_setpoint),
    .vertical_setpoint   (vertical_setpoint),
    .fire_rate           (fire_rate),
    .shooter_on          (shooter_on),
    .shooter_speed       (shooter_speed),
    .laser_on            (laser_on),
    .gear_down           (gear_down),
    .sticks_centered     (sticks_centered)
  );

endmodule

### src/dfgs_checker.sv
// port-level checks for the receiver frame decoder and their binding
module dfgs_checker import dfgs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         input_mode,
  input logic signed [14:0] horizontal_setpoint,
  input logic [9:0]         fire_rate,
  input logic               shooter_on,
  input logic               laser_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> input_mode != 2'd3)
    else $error("illegal mode code");

  a_horiz_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> horizontal_setpoint >= -15'sd13000 && horizontal_setpoint <= 15'sd5000)
    else $error("horizontal setpoint out of range");

  a_fire_shooter: assert property (@(posedge clk) disable iff (rst)
    out_valid && fire_rate != 10'd0 |-> shooter_on && laser_on)
    else $error("firing without shooter");

endmodule

bind dbus_frame_gimbal_setpoint dfgs_checker u_dfgs_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .input_mode          (input_mode),
  .horizontal_setpoint (horizontal_setpoint),
  .fire_rate           (fire_rate),
  .shooter_on          (shooter_on),
  .laser_on            (laser_on)
);
